// ----- src/ssrt_pkg.sv -----
package ssrt_pkg;

  // Table size
  localparam int SLOT_COUNT   = 16;
  localparam int STATUS_WORDS = 52;

  // Field widths
  localparam int STATE_W  = 8;
  localparam int RESULT_W = 32;
  localparam int OUT_W    = 16;
  localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WORD_W   = $clog2(STATUS_WORDS);
  localparam int CNT_W    = $clog2(STATUS_WORDS + 1);
  localparam int RUN_W    = $clog2(SLOT_COUNT + 1);

  // Command queue between front and back; depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes on the input tuser
  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_RUNNING_CODE = 1'b0,
    CFG_HIGHEST_CODE = 1'b1
  } cfg_index_t;

  // Classified command as queued
  typedef enum logic [1:0] {
    K_UPDATE,
    K_CLEAR,
    K_READ,
    K_READ_ERR
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SLOT_W-1:0]    slot;
    logic [STATE_W-1:0]   state;
    logic [RESULT_W-1:0]  result;
    logic [WORD_W-1:0]    offset;
    logic [CNT_W-1:0]     count;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EMIT
  } back_state_t;

  // Status word decode
  typedef enum logic [2:0] {
    SEL_ONE,
    SEL_COUNT,
    SEL_MASK_HI,
    SEL_MASK_LO,
    SEL_SLOT,
    SEL_ZERO
  } sel_t;

  typedef enum logic [1:0] {
    PART_STATE,
    PART_HIGH,
    PART_LOW
  } part_t;

  typedef struct packed {
    sel_t              sel;
    logic [SLOT_W-1:0] slot;
    part_t             part;
  } word_map_t;

  // Word 0..3 are header words, then three words per slot
  function automatic word_map_t map_word(input logic [WORD_W-1:0] w);
    word_map_t m;
    m.sel  = SEL_ZERO;
    m.slot = '0;
    m.part = PART_STATE;
    if (w == WORD_W'(0)) begin
      m.sel = SEL_ONE;
    end else if (w == WORD_W'(1)) begin
      m.sel = SEL_COUNT;
    end else if (w == WORD_W'(2)) begin
      m.sel = SEL_MASK_HI;
    end else if (w == WORD_W'(3)) begin
      m.sel = SEL_MASK_LO;
    end else begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (int'(w) == 4 + 3 * s) begin
          m.sel  = SEL_SLOT;
          m.slot = SLOT_W'(s);
          m.part = PART_STATE;
        end
        if (int'(w) == 5 + 3 * s) begin
          m.sel  = SEL_SLOT;
          m.slot = SLOT_W'(s);
          m.part = PART_HIGH;
        end
        if (int'(w) == 6 + 3 * s) begin
          m.sel  = SEL_SLOT;
          m.slot = SLOT_W'(s);
          m.part = PART_LOW;
        end
      end
    end
    return m;
  endfunction

endpackage

// ----- src/ssrt_front.sv -----
module ssrt_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // slot_number[7:0], slot_state[15:8], slot_result[47:16],
  // word_offset[63:48], word_count[79:64]
  input  logic [79:0]                  s_tdata,
  // cmd[1:0]
  input  logic [1:0]                   s_tuser,
  input  logic [ssrt_pkg::STATE_W-1:0] highest_state_code,
  input  logic                         q_full,
  output ssrt_pkg::push_t              push
);

  logic [7:0]                    slot_number;
  logic [ssrt_pkg::STATE_W-1:0]  slot_state;
  logic [ssrt_pkg::RESULT_W-1:0] slot_result;
  logic [15:0]                   word_offset;
  logic [15:0]                   word_count;
  logic [16:0]                   win_end;
  logic                          upd_ok;
  logic                          read_bad;
  logic                          keep;
  logic [7:0]                    slot_dec;

  assign slot_number = s_tdata[7:0];
  assign slot_state  = s_tdata[15:8];
  assign slot_result = s_tdata[47:16];
  assign word_offset = s_tdata[63:48];
  assign word_count  = s_tdata[79:64];

  assign s_tready = !q_full;

  // Update checks: slot counted from 1, state within the accepted range
  assign slot_dec = slot_number - 8'd1;
  assign upd_ok   = (slot_number != 8'd0) &&
                    (slot_number <= 8'(ssrt_pkg::SLOT_COUNT)) &&
                    (slot_state <= highest_state_code);

  // Read window check
  assign win_end  = {1'b0, word_offset} + {1'b0, word_count};
  assign read_bad = (word_count == 16'd0) ||
                    (win_end > 17'(ssrt_pkg::STATUS_WORDS));

  // Classify; bad updates and the unused code are dropped here
  always_comb begin
    push.entry.kind   = ssrt_pkg::K_CLEAR;
    push.entry.slot   = slot_dec[ssrt_pkg::SLOT_W-1:0];
    push.entry.state  = slot_state;
    push.entry.result = slot_result;
    push.entry.offset = word_offset[ssrt_pkg::WORD_W-1:0];
    push.entry.count  = word_count[ssrt_pkg::CNT_W-1:0];
    keep = 1'b0;
    priority if (s_tuser == ssrt_pkg::CMD_UPDATE) begin
      push.entry.kind = ssrt_pkg::K_UPDATE;
      keep = upd_ok;
    end else if (s_tuser == ssrt_pkg::CMD_CLEAR) begin
      push.entry.kind = ssrt_pkg::K_CLEAR;
      keep = 1'b1;
    end else if (s_tuser == ssrt_pkg::CMD_READ) begin
      push.entry.kind = read_bad ? ssrt_pkg::K_READ_ERR : ssrt_pkg::K_READ;
      keep = 1'b1;
    end else begin
      keep = 1'b0;
    end
    push.push = s_tvalid && s_tready && keep;
  end

endmodule

// ----- src/ssrt_queue.sv -----
module ssrt_queue (
  input  logic             clk,
  input  logic             rst,
  input  ssrt_pkg::push_t  push,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output ssrt_pkg::entry_t head
);

  ssrt_pkg::entry_t            slots [ssrt_pkg::QUEUE_DEPTH];
  logic [ssrt_pkg::QPTR_W-1:0] wr_ptr;
  logic [ssrt_pkg::QPTR_W-1:0] rd_ptr;
  logic [ssrt_pkg::QCNT_W-1:0] fill;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (fill == ssrt_pkg::QCNT_W'(ssrt_pkg::QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push.push && !full;
  assign do_pop  = pop && valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.entry;
  end

endmodule

// ----- src/ssrt_back.sv -----
module ssrt_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  ssrt_pkg::entry_t             q_entry,
  output logic                         q_pop,
  input  logic [ssrt_pkg::STATE_W-1:0] running_state_code,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // word_value[15:0]
  output logic [15:0]                  m_tdata,
  // read_error[0]
  output logic [0:0]                   m_tuser,
  output logic                         m_tlast
);

  ssrt_pkg::back_state_t         state;
  ssrt_pkg::back_state_t         state_next;
  logic [ssrt_pkg::STATE_W-1:0]  state_store  [ssrt_pkg::SLOT_COUNT];
  logic [ssrt_pkg::RESULT_W-1:0] result_store [ssrt_pkg::SLOT_COUNT];
  logic [ssrt_pkg::WORD_W-1:0]   cur;
  logic [ssrt_pkg::CNT_W-1:0]    remain;
  logic [ssrt_pkg::SLOT_COUNT-1:0] run_mask;
  logic [ssrt_pkg::SLOT_COUNT-1:0] run_hit;
  logic [ssrt_pkg::RUN_W-1:0]    run_count;
  logic [31:0]                   mask_word;
  ssrt_pkg::word_map_t           wmap;
  logic [ssrt_pkg::OUT_W-1:0]    word_val;
  logic                          out_free;
  logic                          do_update;
  logic                          do_clear;
  logic                          start_read;
  logic                          do_scan;
  logic                          load_err;
  logic                          load_word;
  logic                          any_state;

  assign out_free = !m_tvalid || m_tready;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= ssrt_pkg::B_IDLE;
    else     state <= state_next;
  end

  // Next state and control strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    do_update  = 1'b0;
    do_clear   = 1'b0;
    start_read = 1'b0;
    do_scan    = 1'b0;
    load_err   = 1'b0;
    load_word  = 1'b0;
    unique case (state)
      ssrt_pkg::B_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.kind)
            ssrt_pkg::K_UPDATE: begin
              q_pop     = 1'b1;
              do_update = 1'b1;
            end
            ssrt_pkg::K_CLEAR: begin
              q_pop    = 1'b1;
              do_clear = 1'b1;
            end
            ssrt_pkg::K_READ: begin
              q_pop      = 1'b1;
              start_read = 1'b1;
              state_next = ssrt_pkg::B_SCAN;
            end
            ssrt_pkg::K_READ_ERR: begin
              if (out_free) begin
                q_pop    = 1'b1;
                load_err = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ssrt_pkg::B_SCAN: begin
        do_scan    = 1'b1;
        state_next = ssrt_pkg::B_EMIT;
      end
      ssrt_pkg::B_EMIT: begin
        if (out_free) begin
          load_word = 1'b1;
          if (remain == ssrt_pkg::CNT_W'(1)) state_next = ssrt_pkg::B_IDLE;
        end
      end
      default: state_next = ssrt_pkg::B_IDLE;
    endcase
  end

  // Slot tables
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int i = 0; i < ssrt_pkg::SLOT_COUNT; i++) begin
        state_store[i]  <= '0;
        result_store[i] <= '0;
      end
    end else if (do_update) begin
      state_store[q_entry.slot]  <= q_entry.state;
      result_store[q_entry.slot] <= q_entry.result;
    end
  end

  // Running slots: one comparator per slot
  always_comb begin
    for (int i = 0; i < ssrt_pkg::SLOT_COUNT; i++) begin
      run_hit[i] = (state_store[i] == running_state_code);
    end
  end

  // Window walk and running summary, taken once per read
  always_ff @(posedge clk) begin
    if (start_read) begin
      cur    <= q_entry.offset;
      remain <= q_entry.count;
    end else if (load_word) begin
      cur    <= cur + 1'b1;
      remain <= remain - 1'b1;
    end
    if (do_scan) begin
      run_mask  <= run_hit;
      run_count <= ssrt_pkg::RUN_W'($countones(run_hit));
    end
  end

  // Status word at the current position
  assign mask_word = 32'(run_mask);
  assign wmap      = ssrt_pkg::map_word(cur);

  always_comb begin
    word_val = '0;
    unique case (wmap.sel)
      ssrt_pkg::SEL_ONE:     word_val = ssrt_pkg::OUT_W'(1);
      ssrt_pkg::SEL_COUNT:   word_val = ssrt_pkg::OUT_W'(run_count);
      ssrt_pkg::SEL_MASK_HI: word_val = mask_word[31:16];
      ssrt_pkg::SEL_MASK_LO: word_val = mask_word[15:0];
      ssrt_pkg::SEL_SLOT: begin
        unique case (wmap.part)
          ssrt_pkg::PART_STATE: word_val = ssrt_pkg::OUT_W'(state_store[wmap.slot]);
          ssrt_pkg::PART_HIGH:  word_val = result_store[wmap.slot][31:16];
          ssrt_pkg::PART_LOW:   word_val = result_store[wmap.slot][15:0];
          default:              word_val = '0;
        endcase
      end
      default: word_val = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_word || load_err) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_err) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
      m_tlast <= 1'b1;
    end else if (load_word) begin
      m_tdata <= word_val;
      m_tuser <= 1'b0;
      m_tlast <= (remain == ssrt_pkg::CNT_W'(1));
    end
  end

  // Any slot state still set
  always_comb begin
    any_state = 1'b0;
    for (int i = 0; i < ssrt_pkg::SLOT_COUNT; i++) begin
      any_state = any_state | (state_store[i] != '0);
    end
  end

  a_emit_remain: assert property (@(posedge clk) disable iff (rst)
    state == ssrt_pkg::B_EMIT |-> remain != '0)
    else $error("window walk with no words left");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == ssrt_pkg::B_EMIT |-> (int'(cur) + int'(remain)) <= ssrt_pkg::STATUS_WORDS)
    else $error("window walk runs past the status map");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && m_tlast)
    else $error("error word not zero or not last");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> !any_state)
    else $error("slot states not cleared");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    load_word && remain == ssrt_pkg::CNT_W'(1) |=> state == ssrt_pkg::B_IDLE && m_tlast)
    else $error("sequencer did not finish on the last word");

endmodule

// ----- src/slot_status_register_table.sv -----
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tdata: slot/state/result/offset/count, s_tuser: cmd
// m        out  m_tvalid/m_tready  m_tdata: word_value, m_tuser: read_error, m_tlast
// cfg      in   cfg_we             cfg_index, cfg_data (no handshake, no read-back)
//
// Update and clear are taken one per cycle while s_tready is high and carried out at the edge
// that pops them from the two-entry command queue. A read pops its command, registers the
// running mask and count, then gives one word per cycle from the output register while
// m_tready is high; a bad window gives its single error word.
// rst is synchronous and active high; it zeroes the slot tables, empties the queue
// and loads the register defaults. A stall on m holds the output word and walk,
// and the queue fills and drops s_tready after two waiting commands.
module slot_status_register_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot_number[7:0], slot_state[15:8], slot_result[47:16],
  // word_offset[63:48], word_count[79:64]
  input  logic [79:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // word_value[15:0]
  output logic [15:0] m_tdata,
  // read_error[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [ssrt_pkg::STATE_W-1:0] running_state_code;
  logic [ssrt_pkg::STATE_W-1:0] highest_state_code;
  ssrt_pkg::push_t              push;
  ssrt_pkg::entry_t             q_head;
  logic                         q_full;
  logic                         q_valid;
  logic                         q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running_state_code <= 8'd1;
      highest_state_code <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssrt_pkg::CFG_RUNNING_CODE: running_state_code <= cfg_data;
        ssrt_pkg::CFG_HIGHEST_CODE: highest_state_code <= cfg_data;
        default: ;
      endcase
    end
  end

  ssrt_front u_front (
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tuser            (s_tuser),
    .highest_state_code (highest_state_code),
    .q_full             (q_full),
    .push               (push)
  );

  ssrt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .head  (q_head)
  );

  ssrt_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_entry            (q_head),
    .q_pop              (q_pop),
    .running_state_code (running_state_code),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tuser            (m_tuser),
    .m_tlast            (m_tlast)
  );

endmodule
